// ===== rtl/core/fvn2d_pkg.sv =====
`default_nettype none
package fvn2d_pkg;

    localparam int MAX_OCTAVES_DEFAULT = 8;
    localparam int COORD_WIDTH_DEFAULT = 16;

    localparam int ADDR_WIDTH = 4;
    localparam int DATA_WIDTH = 32;

    localparam logic [1:0] REG_FREQUENCY    = 2'd0;
    localparam logic [1:0] REG_OCTAVE_COUNT = 2'd1;
    localparam logic [1:0] REG_SEED_OFFSET  = 2'd2;

    localparam logic [15:0] FREQUENCY_RESET    = 16'd1311;
    localparam logic [3:0]  OCTAVE_COUNT_RESET = 4'd5;
    localparam logic [7:0]  SEED_OFFSET_RESET  = 8'd57;

    // smoothstep constant 3.0 in Q2.16
    localparam logic [17:0] SMOOTH_THREE = 18'd196608;

    localparam logic [15:0] NOISE_MAX = 16'd65280;

    localparam logic [7:0] PERM_TABLE [0:255] = '{
        8'd208, 8'd34, 8'd231, 8'd213, 8'd32, 8'd248, 8'd233, 8'd56, 8'd161, 8'd78, 8'd24,
        8'd140, 8'd71, 8'd48, 8'd140, 8'd254, 8'd245, 8'd255, 8'd247, 8'd247, 8'd40,
        8'd185, 8'd248, 8'd251, 8'd245, 8'd28, 8'd124, 8'd204, 8'd204, 8'd76, 8'd36, 8'd1,
        8'd107, 8'd28, 8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128, 8'd167, 8'd204,
        8'd9, 8'd92, 8'd217, 8'd54, 8'd239, 8'd174, 8'd173, 8'd102, 8'd193, 8'd189, 8'd190,
        8'd121, 8'd100, 8'd108, 8'd167, 8'd44, 8'd43, 8'd77, 8'd180, 8'd204, 8'd8, 8'd81,
        8'd70, 8'd223, 8'd11, 8'd38, 8'd24, 8'd254, 8'd210, 8'd210, 8'd177, 8'd32, 8'd81,
        8'd195, 8'd243, 8'd125, 8'd8, 8'd169, 8'd112, 8'd32, 8'd97, 8'd53, 8'd195, 8'd13,
        8'd203, 8'd9, 8'd47, 8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
        8'd181, 8'd235, 8'd193, 8'd206, 8'd70, 8'd180, 8'd174, 8'd0, 8'd167, 8'd181, 8'd41,
        8'd164, 8'd30, 8'd116, 8'd127, 8'd198, 8'd245, 8'd146, 8'd87, 8'd224, 8'd149,
        8'd206, 8'd57, 8'd4, 8'd192, 8'd210, 8'd65, 8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
        8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40, 8'd35, 8'd195, 8'd38, 8'd58, 8'd65,
        8'd207, 8'd215, 8'd253, 8'd65, 8'd85, 8'd208, 8'd76, 8'd62, 8'd3, 8'd237, 8'd55,
        8'd89, 8'd232, 8'd50, 8'd217, 8'd64, 8'd244, 8'd157, 8'd199, 8'd121, 8'd252, 8'd90,
        8'd17, 8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234, 8'd177, 8'd73,
        8'd174, 8'd193, 8'd100, 8'd192, 8'd143, 8'd97, 8'd53, 8'd145, 8'd135, 8'd19,
        8'd103, 8'd13, 8'd90, 8'd135, 8'd151, 8'd199, 8'd91, 8'd239, 8'd247, 8'd33, 8'd39,
        8'd145, 8'd101, 8'd120, 8'd99, 8'd3, 8'd186, 8'd86, 8'd99, 8'd41, 8'd237, 8'd203,
        8'd111, 8'd79, 8'd220, 8'd135, 8'd158, 8'd42, 8'd30, 8'd154, 8'd120, 8'd67, 8'd87,
        8'd167, 8'd135, 8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21, 8'd233,
        8'd58, 8'd129, 8'd233, 8'd142, 8'd39, 8'd128, 8'd211, 8'd118, 8'd137, 8'd139,
        8'd255, 8'd114, 8'd20, 8'd218, 8'd113, 8'd154, 8'd27, 8'd127, 8'd246, 8'd250, 8'd1,
        8'd8, 8'd198, 8'd250, 8'd209, 8'd92, 8'd222, 8'd173, 8'd21, 8'd88, 8'd102, 8'd219
    };

    // floor(2^32 / (2^d - 1))
    function automatic logic [32:0] recip(input logic [4:0] d);
        logic [32:0] r;
        begin
            case (d)
                5'd2:    r = 33'h055555555;
                5'd3:    r = 33'h024924924;
                5'd4:    r = 33'h011111111;
                5'd5:    r = 33'h008421084;
                5'd6:    r = 33'h004104104;
                5'd7:    r = 33'h002040810;
                5'd8:    r = 33'h001010101;
                5'd9:    r = 33'h000804020;
                5'd10:   r = 33'h000401004;
                5'd11:   r = 33'h000200400;
                5'd12:   r = 33'h000100100;
                5'd13:   r = 33'h000080040;
                5'd14:   r = 33'h000040010;
                5'd15:   r = 33'h000020004;
                5'd16:   r = 33'h000010001;
                default: r = 33'h100000000;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fractal_value_noise_2d_unit.sv =====
// Fractal value noise, 2-D.
// Input channel: coord_x, coord_y with in_valid/in_ready. Output channel:
// noise_value (unsigned Q0.16) with out_valid/out_ready, one result per item.
// APB port: frequency at 0x0, octave_count at 0x4, seed_offset at 0x8.
// Write registers only while no item is in flight.
// Pipeline: 10 register stages. Throughput: one item per cycle while the
// output is not stalled; every octave has its own lane, so all octaves of an
// item move through the pipeline together. The divide by the octave weight
// total is a reciprocal multiply split into two partial products plus a
// one-step fixup. The last pipeline stage is the output register. When
// out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; no item is lost or repeated.
// Reset: pipeline empties, registers return to frequency 1311,
// octave_count 5, seed_offset 57.
`default_nettype none
module fractal_value_noise_2d_unit #(
    parameter int MAX_OCTAVES = fvn2d_pkg::MAX_OCTAVES_DEFAULT,
    parameter int COORD_WIDTH = fvn2d_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] coord_x,
    input  wire logic [15:0] coord_y,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      noise_value,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [fvn2d_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [fvn2d_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [fvn2d_pkg::DATA_WIDTH-1:0]      prdata,
    output logic             pready
);

    localparam int NSTAGE = 10;
    localparam int SW     = 24 + MAX_OCTAVES;
    localparam int NP     = (MAX_OCTAVES + 1) / 2;
    localparam logic [15:0] CMASK =
        (COORD_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << COORD_WIDTH) - 32'd1);

    logic [15:0] frequency_reg;
    logic [3:0]  octave_count_reg;
    logic [7:0]  seed_offset_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;
    logic [4:0]  d_eff;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frequency_reg    <= fvn2d_pkg::FREQUENCY_RESET;
            octave_count_reg <= fvn2d_pkg::OCTAVE_COUNT_RESET;
            seed_offset_reg  <= fvn2d_pkg::SEED_OFFSET_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                fvn2d_pkg::REG_FREQUENCY:    frequency_reg    <= pwdata[15:0];
                fvn2d_pkg::REG_OCTAVE_COUNT: octave_count_reg <= pwdata[3:0];
                fvn2d_pkg::REG_SEED_OFFSET:  seed_offset_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            fvn2d_pkg::REG_FREQUENCY:    prdata = {16'd0, frequency_reg};
            fvn2d_pkg::REG_OCTAVE_COUNT: prdata = {28'd0, octave_count_reg};
            fvn2d_pkg::REG_SEED_OFFSET:  prdata = {24'd0, seed_offset_reg};
            default:                     prdata = '0;
        endcase
    end

    always_comb
    begin
        if (octave_count_reg == 4'd0)
            d_eff = 5'd1;
        else if ({1'b0, octave_count_reg} > 5'(MAX_OCTAVES))
            d_eff = 5'(MAX_OCTAVES);
        else
            d_eff = {1'b0, octave_count_reg};
    end

    // pipeline control
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic              adv;

    assign adv       = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NSTAGE-1];
    assign vld_next  = {vld_reg[NSTAGE-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // stage 1: scale coordinates
    logic [31:0] px_reg, py_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= (coord_x & CMASK) * frequency_reg;
            py_reg <= (coord_y & CMASK) * frequency_reg;
        end
    end

    // octave lanes
    logic [7:0]  ix_reg   [MAX_OCTAVES];
    logic [15:0] fx_reg   [MAX_OCTAVES];
    logic [15:0] fy_reg   [MAX_OCTAVES];
    logic [15:0] sqx_reg  [MAX_OCTAVES];
    logic [15:0] sqy_reg  [MAX_OCTAVES];
    logic [7:0]  row0_reg [MAX_OCTAVES];
    logic [7:0]  row1_reg [MAX_OCTAVES];
    logic [15:0] wx_reg   [MAX_OCTAVES];
    logic [15:0] wy_reg   [MAX_OCTAVES];
    logic [15:0] wy2_reg  [MAX_OCTAVES];
    logic [7:0]  c00_reg  [MAX_OCTAVES];
    logic [7:0]  c10_reg  [MAX_OCTAVES];
    logic [7:0]  c01_reg  [MAX_OCTAVES];
    logic [7:0]  c11_reg  [MAX_OCTAVES];
    logic [23:0] lo_reg   [MAX_OCTAVES];
    logic [23:0] hi_reg   [MAX_OCTAVES];
    logic [23:0] n_reg    [MAX_OCTAVES];
    logic [SW-1:0] term   [MAX_OCTAVES];

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_lane
        logic [15:0] fx, fy;
        logic [7:0]  ix, iy;
        logic [31:0] sqx_full, sqy_full;
        logic [33:0] wx_full, wy_full;
        logic [23:0] lo, hi, n;
        logic [23:0] dlo, dhi;
        logic [39:0] dn;
        logic [23:0] dy;
        logic [4:0]  sh;

        assign fx = 16'(px_reg << i);
        assign fy = 16'(py_reg << i);
        assign ix = 8'(px_reg >> (16 - i));
        assign iy = 8'(py_reg >> (16 - i));
        assign sqx_full = fx * fx;
        assign sqy_full = fy * fy;

        assign wx_full = sqx_reg[i] * (fvn2d_pkg::SMOOTH_THREE - {1'b0, fx_reg[i], 1'b0});
        assign wy_full = sqy_reg[i] * (fvn2d_pkg::SMOOTH_THREE - {1'b0, fy_reg[i], 1'b0});

        always_comb
        begin
            if (c10_reg[i] >= c00_reg[i])
            begin
                dlo = 24'(c10_reg[i] - c00_reg[i]) * wx_reg[i];
                lo  = {c00_reg[i], 16'd0} + dlo;
            end
            else
            begin
                dlo = 24'(c00_reg[i] - c10_reg[i]) * wx_reg[i];
                lo  = {c00_reg[i], 16'd0} - dlo;
            end
            if (c11_reg[i] >= c01_reg[i])
            begin
                dhi = 24'(c11_reg[i] - c01_reg[i]) * wx_reg[i];
                hi  = {c01_reg[i], 16'd0} + dhi;
            end
            else
            begin
                dhi = 24'(c01_reg[i] - c11_reg[i]) * wx_reg[i];
                hi  = {c01_reg[i], 16'd0} - dhi;
            end
        end

        always_comb
        begin
            if (hi_reg[i] >= lo_reg[i])
            begin
                dn = (hi_reg[i] - lo_reg[i]) * wy2_reg[i];
                dy = dn[39:16];
                n  = lo_reg[i] + dy;
            end
            else
            begin
                dn = (lo_reg[i] - hi_reg[i]) * wy2_reg[i];
                dy = dn[39:16];
                n  = lo_reg[i] - dy;
            end
        end

        assign sh = d_eff - 5'd1 - 5'(i);
        assign term[i] = (5'(i) < d_eff) ? (SW'(n_reg[i]) << sh) : '0;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                // stage 2
                ix_reg[i]   <= ix;
                fx_reg[i]   <= fx;
                fy_reg[i]   <= fy;
                sqx_reg[i]  <= sqx_full[31:16];
                sqy_reg[i]  <= sqy_full[31:16];
                row0_reg[i] <= fvn2d_pkg::PERM_TABLE[8'(iy + seed_offset_reg)];
                row1_reg[i] <= fvn2d_pkg::PERM_TABLE[8'(iy + 8'd1 + seed_offset_reg)];
                // stage 3
                wx_reg[i]   <= wx_full[31:16];
                wy_reg[i]   <= wy_full[31:16];
                c00_reg[i]  <= fvn2d_pkg::PERM_TABLE[8'(row0_reg[i] + ix_reg[i])];
                c10_reg[i]  <= fvn2d_pkg::PERM_TABLE[8'(row0_reg[i] + ix_reg[i] + 8'd1)];
                c01_reg[i]  <= fvn2d_pkg::PERM_TABLE[8'(row1_reg[i] + ix_reg[i])];
                c11_reg[i]  <= fvn2d_pkg::PERM_TABLE[8'(row1_reg[i] + ix_reg[i] + 8'd1)];
                // stage 4
                lo_reg[i]   <= lo;
                hi_reg[i]   <= hi;
                wy2_reg[i]  <= wy_reg[i];
                // stage 5
                n_reg[i]    <= n;
            end
        end
    end

    // stage 6: pair sums
    logic [SW-1:0] pair_reg [NP];
    for (genvar k = 0; k < NP; k++)
    begin : g_pair
        logic [SW-1:0] psum;
        if (2 * k + 1 < MAX_OCTAVES)
        begin : g_two
            assign psum = term[2*k] + term[2*k+1];
        end
        else
        begin : g_one
            assign psum = term[2*k];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                pair_reg[k] <= psum;
        end
    end

    // stage 7: total, drop the factor 256
    logic [SW-1:0] total;
    logic [31:0]   t_reg;
    always_comb
    begin
        total = '0;
        for (int k = 0; k < NP; k++)
            total = total + pair_reg[k];
    end

    // stage 8: reciprocal partial products
    logic [32:0] rcp;
    logic [48:0] pl_reg, ph_reg;
    logic [31:0] t8_reg;
    assign rcp = fvn2d_pkg::recip(d_eff);

    // stage 9: quotient estimate
    logic [64:0] acc;
    logic [31:0] q0_reg;
    logic [31:0] t9_reg;
    assign acc = {ph_reg, 16'd0} + 65'(pl_reg);

    // stage 10: one-step fixup into the output register
    logic [47:0] qm, rem, m;
    logic [31:0] q;
    logic [15:0] noise_reg;
    always_comb
    begin
        m   = (48'd1 << d_eff) - 48'd1;
        qm  = ({16'd0, q0_reg} << d_eff) - {16'd0, q0_reg};
        rem = {16'd0, t9_reg} - qm;
        q   = (rem >= m) ? q0_reg + 32'd1 : q0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg     <= 32'(total >> 8);
            t8_reg    <= t_reg;
            pl_reg    <= t_reg[15:0] * rcp;
            ph_reg    <= t_reg[31:16] * rcp;
            t9_reg    <= t8_reg;
            q0_reg    <= acc[63:32];
            noise_reg <= q[15:0];
        end
    end

    assign noise_value = noise_reg;

endmodule
`default_nettype wire

// ===== rtl/core/fvn2d_checker.sv =====
`default_nettype none
module fvn2d_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] noise_value,
    input wire logic        in_ready,
    input wire logic        pready
);

    // a waiting result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(noise_value))
        else $error("output item dropped or changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> noise_value <= fvn2d_pkg::NOISE_MAX)
        else $error("noise above full scale");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline stalled");

    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown right after reset");

endmodule

bind fractal_value_noise_2d_unit fvn2d_checker u_fvn2d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .noise_value (noise_value),
    .in_ready    (in_ready),
    .pready      (pready)
);
`default_nettype wire
